// File: sv/triangle_tangent_frame_defines.svh
// Assertion macros shared by the triangle tangent frame RTL.
`ifndef TRIANGLE_TANGENT_FRAME_DEFINES_SVH
`define TRIANGLE_TANGENT_FRAME_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define TTF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define TTF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ttf_pkg.sv
// Types and constants of the triangle tangent frame block.
`default_nettype none

package ttf_pkg;

    // Wide signed accumulator for det and raw frame vectors
    localparam int WIDE_W = 52;
    localparam int UNIT_W = 16;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic signed [23:0] tex_u;
        logic signed [23:0] tex_v;
    } in_t;

    typedef struct packed {
        logic signed [15:0] tangent_x;
        logic signed [15:0] tangent_y;
        logic signed [15:0] tangent_z;
        logic signed [15:0] binormal_x;
        logic signed [15:0] binormal_y;
        logic signed [15:0] binormal_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic               degenerate;
    } out_t;

    typedef logic signed [WIDE_W-1:0] wide_t;
    typedef wide_t [2:0]              wvec_t;
    typedef logic signed [UNIT_W-1:0] unit_t;
    typedef unit_t [2:0]              uvec_t;

    // Normalizer status back to the sequencer
    typedef struct packed {
        logic done;
        logic ok;
    } nrm_stat_t;

    // Result slots of the dot-difference sequence
    localparam logic [3:0] RES_DET = 4'd0;
    localparam logic [3:0] RES_TX  = 4'd1;
    localparam logic [3:0] RES_TY  = 4'd2;
    localparam logic [3:0] RES_TZ  = 4'd3;
    localparam logic [3:0] RES_BX  = 4'd4;
    localparam logic [3:0] RES_BY  = 4'd5;
    localparam logic [3:0] RES_BZ  = 4'd6;
    localparam logic [3:0] RES_NX  = 4'd7;
    localparam logic [3:0] RES_NY  = 4'd8;
    localparam logic [3:0] RES_NZ  = 4'd9;

    // Vector currently in the normalizer
    localparam logic [1:0] SEL_TAN = 2'd0;
    localparam logic [1:0] SEL_BIN = 2'd1;
    localparam logic [1:0] SEL_NRM = 2'd2;

    // Vertex position within a triangle
    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;

endpackage

`default_nettype wire

// File: sv/ttf_norm.sv
// Bit-serial vector normalizer: scale, sum of squares, square root, divides.
`default_nettype none

module ttf_norm
    import ttf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire wvec_t     vec,
    input  wire logic      flip,
    output nrm_stat_t      stat,
    output uvec_t          unit
);

    typedef enum logic [8:0] {
        N_IDLE  = 9'b000000001,
        N_SHIFT = 9'b000000010,
        N_SQL   = 9'b000000100,
        N_SQ    = 9'b000001000,
        N_SQA   = 9'b000010000,
        N_SQRT  = 9'b000100000,
        N_DVL   = 9'b001000000,
        N_DIV   = 9'b010000000,
        N_DONE  = 9'b100000000
    } nstate_t;

    nstate_t                  state_reg, state_next;
    logic [2:0][WIDE_W-1:0]   mag_reg, mag_next;
    logic [2:0]               neg_reg, neg_next;
    logic [1:0]               idx_reg, idx_next;
    logic [4:0]               cnt_reg, cnt_next;
    logic [29:0]              sqa_reg, sqa_next;
    logic [59:0]              sqp_reg, sqp_next;
    logic [61:0]              sum_reg, sum_next;
    logic [32:0]              rem_reg, rem_next;
    logic [30:0]              root_reg, root_next;
    logic [15:0]              dvq_reg, dvq_next;
    uvec_t                    unit_reg, unit_next;
    logic                     ok_reg, ok_next;

    logic [WIDE_W-1:0]        abs_v [3];
    logic [30:0]              sq_sum;
    logic [32:0]              rt_rem2;
    logic [32:0]              rt_trial;
    logic [45:0]              dv_num;
    logic [32:0]              dv_r2;
    logic [32:0]              dv_d;
    logic [15:0]              dv_q;
    logic                     big;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        idx_reg  <= idx_next;
        cnt_reg  <= cnt_next;
        sqa_reg  <= sqa_next;
        sqp_reg  <= sqp_next;
        sum_reg  <= sum_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        dvq_reg  <= dvq_next;
        unit_reg <= unit_next;
        ok_reg   <= ok_next;
    end

    // Step arithmetic, one bit or one digit per cycle
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            abs_v[i] = vec[i][WIDE_W-1] ? WIDE_W'(-vec[i]) : WIDE_W'(vec[i]);
        end
        big      = (|mag_reg[0][WIDE_W-1:30]) | (|mag_reg[1][WIDE_W-1:30])
                 | (|mag_reg[2][WIDE_W-1:30]);
        sq_sum   = {1'b0, sqp_reg[59:30]} + (sqp_reg[0] ? {1'b0, sqa_reg} : 31'd0);
        rt_rem2  = {rem_reg[30:0], sum_reg[61:60]};
        rt_trial = {root_reg, 2'b01};
        dv_num   = {1'b0, mag_reg[idx_reg][29:0], 15'd0} + {15'd0, root_reg};
        dv_r2    = {rem_reg[31:0], dvq_reg[15]};
        dv_d     = {1'b0, root_reg, 1'b0};
        dv_q     = {dvq_reg[14:0], dv_r2 >= dv_d};
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        sqa_next   = sqa_reg;
        sqp_next   = sqp_reg;
        sum_next   = sum_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        dvq_next   = dvq_reg;
        unit_next  = unit_reg;
        ok_next    = ok_reg;
        case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_next[i] = abs_v[i];
                        neg_next[i] = vec[i][WIDE_W-1] ^ flip;
                    end
                    sum_next = '0;
                    idx_next = '0;
                    if ((abs_v[0] | abs_v[1] | abs_v[2]) == '0)
                    begin
                        ok_next    = 1'b0;
                        state_next = N_DONE;
                    end
                    else
                    begin
                        ok_next    = 1'b1;
                        state_next = N_SHIFT;
                    end
                end
            end
            // Bring the largest magnitude below 2^30
            N_SHIFT:
            begin
                if (big)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_next[i] = mag_reg[i] >> 1;
                    end
                end
                else
                begin
                    state_next = N_SQL;
                end
            end
            N_SQL:
            begin
                sqa_next   = mag_reg[idx_reg][29:0];
                sqp_next   = {30'd0, mag_reg[idx_reg][29:0]};
                cnt_next   = '0;
                state_next = N_SQ;
            end
            N_SQ:
            begin
                sqp_next = {sq_sum, sqp_reg[29:1]};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd29)
                begin
                    state_next = N_SQA;
                end
            end
            N_SQA:
            begin
                sum_next = sum_reg + {2'd0, sqp_reg};
                if (idx_reg == 2'd2)
                begin
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = '0;
                    state_next = N_SQRT;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = N_SQL;
                end
            end
            // Restoring square root, two radicand bits a cycle
            N_SQRT:
            begin
                sum_next = {sum_reg[59:0], 2'b00};
                if (rt_rem2 >= rt_trial)
                begin
                    rem_next  = rt_rem2 - rt_trial;
                    root_next = {root_reg[29:0], 1'b1};
                end
                else
                begin
                    rem_next  = rt_rem2;
                    root_next = {root_reg[29:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd30)
                begin
                    idx_next   = '0;
                    state_next = N_DVL;
                end
            end
            // Rounded quotient a*16384/L, one quotient bit a cycle
            N_DVL:
            begin
                rem_next   = {3'd0, dv_num[45:16]};
                dvq_next   = dv_num[15:0];
                cnt_next   = '0;
                state_next = N_DIV;
            end
            N_DIV:
            begin
                rem_next = (dv_r2 >= dv_d) ? dv_r2 - dv_d : dv_r2;
                dvq_next = dv_q;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd15)
                begin
                    unit_next[idx_reg] = neg_reg[idx_reg] ? unit_t'(-dv_q) : unit_t'(dv_q);
                    if (idx_reg == 2'd2)
                    begin
                        state_next = N_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = N_DVL;
                    end
                end
            end
            N_DONE:
            begin
                state_next = N_IDLE;
            end
            default:
            begin
                state_next = N_IDLE;
            end
        endcase
    end

    assign stat.done = (state_reg == N_DONE);
    assign stat.ok   = ok_reg;
    assign unit      = unit_reg;

endmodule

`default_nettype wire

// File: sv/triangle_tangent_frame.sv
// Triangle tangent frame: top level with vertex capture and bit-serial product sequencer.
// One result per three vertices. The first two vertices of a triangle are captured and held;
// the third starts a computation that ends in the result (a degenerate triangle
// finishes earlier). Its length is set by the bit-serial multiplier (20 products,
// each: load, 25 shift-add steps, accumulate) and by the three passes of the
// normalizer (up to 19 scaling shifts for the tangent and binormal, then three
// squares, a square root and three divides). While it runs, in_ready is low; the result
// waits in an output register, and the first two vertices of the next triangle are
// taken even while it waits.
`default_nettype none
`include "triangle_tangent_frame_defines.svh"

module triangle_tangent_frame
    import ttf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire in_t   in_data,
    output logic       out_valid,
    input  wire logic  out_ready,
    output out_t       out_data
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOAD  = 7'b0000010,
        S_MUL   = 7'b0000100,
        S_ACC   = 7'b0001000,
        S_NGO   = 7'b0010000,
        S_NWAIT = 7'b0100000,
        S_FIN   = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    logic [1:0]            phase_reg, phase_next;
    logic                  out_valid_reg, out_valid_next;
    out_t                  out_reg, out_next;
    in_t                   held_reg [2];
    logic signed [24:0]    e1_reg [3];
    logic signed [24:0]    e2_reg [3];
    logic signed [24:0]    du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic [3:0]            ridx_reg, ridx_next;
    logic                  k_reg, k_next;
    logic [24:0]           mula_reg, mula_next;
    logic [49:0]           prod_reg, prod_next;
    logic                  mneg_reg, mneg_next;
    logic [4:0]            cnt_reg, cnt_next;
    wide_t                 acc_reg, acc_next;
    wide_t                 res_reg [10];
    wide_t                 res_wr;
    logic                  res_we;
    logic [1:0]            sel_reg, sel_next;
    logic                  degen_reg, degen_next;
    uvec_t                 t_reg, t_next;
    uvec_t                 b_reg, b_next;
    uvec_t                 n_reg, n_next;

    logic signed [24:0]    op_a, op_b;
    logic [25:0]           mul_sum;
    wide_t                 term;
    logic                  in_fire, third_fire;
    logic                  nrm_start;
    wvec_t                 nrm_vec;
    logic                  nrm_flip;
    nrm_stat_t             nrm_stat;
    uvec_t                 nrm_unit;

    function automatic logic signed [24:0] sx16(unit_t v);
        return {{9{v[15]}}, v};
    endfunction

    assign in_ready   = (state_reg == S_IDLE) && ((phase_reg != PH_THIRD) || !out_valid_reg);
    assign in_fire    = in_valid && in_ready;
    assign third_fire = in_fire && (phase_reg == PH_THIRD);
    assign out_valid  = out_valid_reg;
    assign out_data   = out_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Vertex hold and edge / UV deltas on the third vertex
    always_ff @(posedge clk)
    begin
        if (in_fire && (phase_reg != PH_THIRD))
        begin
            held_reg[phase_reg[0]] <= in_data;
        end
        if (third_fire)
        begin
            e1_reg[0] <= 25'(held_reg[1].pos_x) - 25'(held_reg[0].pos_x);
            e1_reg[1] <= 25'(held_reg[1].pos_y) - 25'(held_reg[0].pos_y);
            e1_reg[2] <= 25'(held_reg[1].pos_z) - 25'(held_reg[0].pos_z);
            e2_reg[0] <= 25'(in_data.pos_x) - 25'(held_reg[0].pos_x);
            e2_reg[1] <= 25'(in_data.pos_y) - 25'(held_reg[0].pos_y);
            e2_reg[2] <= 25'(in_data.pos_z) - 25'(held_reg[0].pos_z);
            du1_reg   <= 25'(held_reg[1].tex_u) - 25'(held_reg[0].tex_u);
            dv1_reg   <= 25'(held_reg[1].tex_v) - 25'(held_reg[0].tex_v);
            du2_reg   <= 25'(in_data.tex_u) - 25'(held_reg[0].tex_u);
            dv2_reg   <= 25'(in_data.tex_v) - 25'(held_reg[0].tex_v);
        end
        if (res_we)
        begin
            res_reg[ridx_reg] <= res_wr;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        out_reg   <= out_next;
        ridx_reg  <= ridx_next;
        k_reg     <= k_next;
        mula_reg  <= mula_next;
        prod_reg  <= prod_next;
        mneg_reg  <= mneg_next;
        cnt_reg   <= cnt_next;
        acc_reg   <= acc_next;
        sel_reg   <= sel_next;
        degen_reg <= degen_next;
        t_reg     <= t_next;
        b_reg     <= b_next;
        n_reg     <= n_next;
    end

    // Operand pair for each difference of products: first term minus second
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (ridx_reg)
            RES_DET:
            begin
                op_a = k_reg ? du2_reg : du1_reg;
                op_b = k_reg ? dv1_reg : dv2_reg;
            end
            RES_TX:
            begin
                op_a = k_reg ? dv1_reg : dv2_reg;
                op_b = k_reg ? e2_reg[0] : e1_reg[0];
            end
            RES_TY:
            begin
                op_a = k_reg ? dv1_reg : dv2_reg;
                op_b = k_reg ? e2_reg[1] : e1_reg[1];
            end
            RES_TZ:
            begin
                op_a = k_reg ? dv1_reg : dv2_reg;
                op_b = k_reg ? e2_reg[2] : e1_reg[2];
            end
            RES_BX:
            begin
                op_a = k_reg ? du2_reg : du1_reg;
                op_b = k_reg ? e1_reg[0] : e2_reg[0];
            end
            RES_BY:
            begin
                op_a = k_reg ? du2_reg : du1_reg;
                op_b = k_reg ? e1_reg[1] : e2_reg[1];
            end
            RES_BZ:
            begin
                op_a = k_reg ? du2_reg : du1_reg;
                op_b = k_reg ? e1_reg[2] : e2_reg[2];
            end
            RES_NX:
            begin
                op_a = k_reg ? sx16(t_reg[2]) : sx16(t_reg[1]);
                op_b = k_reg ? sx16(b_reg[1]) : sx16(b_reg[2]);
            end
            RES_NY:
            begin
                op_a = k_reg ? sx16(t_reg[0]) : sx16(t_reg[2]);
                op_b = k_reg ? sx16(b_reg[2]) : sx16(b_reg[0]);
            end
            RES_NZ:
            begin
                op_a = k_reg ? sx16(t_reg[1]) : sx16(t_reg[0]);
                op_b = k_reg ? sx16(b_reg[0]) : sx16(b_reg[1]);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Shift-add step and signed product term
    always_comb
    begin
        mul_sum = {1'b0, prod_reg[49:25]} + (prod_reg[0] ? {1'b0, mula_reg} : 26'd0);
        term    = mneg_reg ? -wide_t'({2'b00, prod_reg}) : wide_t'({2'b00, prod_reg});
    end

    // Normalizer input: raw tangent, raw binormal or raw normal
    always_comb
    begin
        case (sel_reg)
            SEL_TAN: nrm_vec = {res_reg[RES_TZ], res_reg[RES_TY], res_reg[RES_TX]};
            SEL_BIN: nrm_vec = {res_reg[RES_BZ], res_reg[RES_BY], res_reg[RES_BX]};
            SEL_NRM: nrm_vec = {res_reg[RES_NZ], res_reg[RES_NY], res_reg[RES_NX]};
            default: nrm_vec = '0;
        endcase
        nrm_flip = (sel_reg != SEL_NRM) && res_reg[RES_DET][WIDE_W-1];
    end

    ttf_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (nrm_start),
        .vec   (nrm_vec),
        .flip  (nrm_flip),
        .stat  (nrm_stat),
        .unit  (nrm_unit)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        ridx_next      = ridx_reg;
        k_next         = k_reg;
        mula_next      = mula_reg;
        prod_next      = prod_reg;
        mneg_next      = mneg_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        sel_next       = sel_reg;
        degen_next     = degen_reg;
        t_next         = t_reg;
        b_next         = b_reg;
        n_next         = n_reg;
        res_we         = 1'b0;
        res_wr         = acc_reg + term;
        nrm_start      = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (phase_reg == PH_THIRD)
                    begin
                        phase_next = PH_FIRST;
                        ridx_next  = RES_DET;
                        k_next     = 1'b0;
                        degen_next = 1'b1;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        phase_next = phase_reg + 2'd1;
                    end
                end
            end
            S_LOAD:
            begin
                mula_next  = op_a[24] ? 25'(-op_a) : 25'(op_a);
                prod_next  = {25'd0, (op_b[24] ? 25'(-op_b) : 25'(op_b))};
                mneg_next  = op_a[24] ^ op_b[24] ^ k_reg;
                cnt_next   = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next = {mul_sum, prod_reg[24:1]};
                cnt_next  = cnt_reg + 5'd1;
                if (cnt_reg == 5'd24)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                if (!k_reg)
                begin
                    acc_next   = term;
                    k_next     = 1'b1;
                    state_next = S_LOAD;
                end
                else
                begin
                    res_we = 1'b1;
                    k_next = 1'b0;
                    if (ridx_reg == RES_BZ)
                    begin
                        sel_next   = SEL_TAN;
                        state_next = (res_reg[RES_DET] == '0) ? S_FIN : S_NGO;
                    end
                    else if (ridx_reg == RES_NZ)
                    begin
                        sel_next   = SEL_NRM;
                        state_next = S_NGO;
                    end
                    else
                    begin
                        ridx_next  = ridx_reg + 4'd1;
                        state_next = S_LOAD;
                    end
                end
            end
            S_NGO:
            begin
                nrm_start  = 1'b1;
                state_next = S_NWAIT;
            end
            S_NWAIT:
            begin
                if (nrm_stat.done)
                begin
                    if (!nrm_stat.ok)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        case (sel_reg)
                            SEL_TAN:
                            begin
                                t_next     = nrm_unit;
                                sel_next   = SEL_BIN;
                                state_next = S_NGO;
                            end
                            SEL_BIN:
                            begin
                                b_next     = nrm_unit;
                                ridx_next  = RES_NX;
                                k_next     = 1'b0;
                                state_next = S_LOAD;
                            end
                            SEL_NRM:
                            begin
                                n_next     = nrm_unit;
                                degen_next = 1'b0;
                                state_next = S_FIN;
                            end
                            default:
                            begin
                                state_next = S_FIN;
                            end
                        endcase
                    end
                end
            end
            S_FIN:
            begin
                if (degen_reg)
                begin
                    out_next            = '0;
                    out_next.degenerate = 1'b1;
                end
                else
                begin
                    out_next.tangent_x  = t_reg[0];
                    out_next.tangent_y  = t_reg[1];
                    out_next.tangent_z  = t_reg[2];
                    out_next.binormal_x = b_reg[0];
                    out_next.binormal_y = b_reg[1];
                    out_next.binormal_z = b_reg[2];
                    out_next.normal_x   = n_reg[0];
                    out_next.normal_y   = n_reg[1];
                    out_next.normal_z   = n_reg[2];
                    out_next.degenerate = 1'b0;
                end
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Checks
    `TTF_ASSERT_NEXT(a_third_starts, third_fire, state_reg == S_LOAD, "third vertex did not start")
    `TTF_ASSERT_NOW(a_norm_done_wait, nrm_stat.done, state_reg == S_NWAIT, "stray normalizer done")
    `TTF_ASSERT_NOW(a_degen_zero, out_valid && out_data.degenerate, out_data.tangent_x == 16'sd0 && out_data.binormal_y == 16'sd0 && out_data.normal_z == 16'sd0, "degenerate result not zeroed")

endmodule

`default_nettype wire

// File: verif/triangle_tangent_frame_test.sv
// Testbench for triangle_tangent_frame: directed and random vertex streams checked against a frame predictor.
`timescale 1ns / 100ps
`default_nettype none

module triangle_tangent_frame_test;
    import ttf_pkg::*;

    // Frame predictor and store of expected triangle results
    class frame_board;
        int unsigned phase;
        longint hx[2], hy[2], hz[2], hu[2], hv[2];
        out_t frames_due[$];
        int unsigned errors;

        function new();
            phase = 0;
            errors = 0;
        endfunction

        function automatic longint isqrt(longint unsigned n);
            longint unsigned r, bit_v;
            r = 0;
            bit_v = 64'd1 << 62;
            while (bit_v > n) bit_v = bit_v >> 2;
            while (bit_v != 0)
            begin
                if (n >= r + bit_v)
                begin
                    n = n - (r + bit_v);
                    r = (r >> 1) + bit_v;
                end
                else
                    r = r >> 1;
                bit_v = bit_v >> 2;
            end
            return longint'(r);
        endfunction

        // Scale vector to Q1.14; zero vector gives 0
        function automatic bit unit_vec(input longint v[3], output longint o[3]);
            longint unsigned mag[3], m, sum, len, q;
            int s;
            m = 0;
            sum = 0;
            s = 0;
            for (int i = 0; i < 3; i++)
            begin
                mag[i] = v[i] < 0 ? longint'(-v[i]) : longint'(v[i]);
                if (mag[i] > m) m = mag[i];
            end
            if (m == 0) return 0;
            while ((m >> s) >= (64'd1 << 30)) s++;
            for (int i = 0; i < 3; i++)
            begin
                mag[i] = mag[i] >> s;
                sum += mag[i] * mag[i];
            end
            len = isqrt(sum);
            for (int i = 0; i < 3; i++)
            begin
                q = (mag[i] * 32768 + len) / (2 * len);
                o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
            end
            return 1;
        endfunction

        function void note_vertex(in_t d);
            longint x, y, z, u, v, du1, dv1, du2, dv2, det;
            longint e1[3], e2[3], tr[3], br[3], t[3], b[3], nr[3], n[3];
            bit ok;
            out_t r;
            x = d.pos_x; y = d.pos_y; z = d.pos_z; u = d.tex_u; v = d.tex_v;
            if (phase < 2)
            begin
                hx[phase] = x; hy[phase] = y; hz[phase] = z;
                hu[phase] = u; hv[phase] = v;
                phase++;
                return;
            end
            phase = 0;
            e1[0] = hx[1] - hx[0]; e1[1] = hy[1] - hy[0]; e1[2] = hz[1] - hz[0];
            e2[0] = x - hx[0]; e2[1] = y - hy[0]; e2[2] = z - hz[0];
            du1 = hu[1] - hu[0]; dv1 = hv[1] - hv[0];
            du2 = u - hu[0]; dv2 = v - hv[0];
            det = du1 * dv2 - du2 * dv1;
            for (int i = 0; i < 3; i++)
            begin
                tr[i] = dv2 * e1[i] - dv1 * e2[i];
                br[i] = du1 * e2[i] - du2 * e1[i];
                if (det < 0)
                begin
                    tr[i] = -tr[i];
                    br[i] = -br[i];
                end
            end
            ok = det != 0;
            if (ok) ok = unit_vec(tr, t);
            if (ok) ok = unit_vec(br, b);
            if (ok)
            begin
                nr[0] = t[1] * b[2] - t[2] * b[1];
                nr[1] = t[2] * b[0] - t[0] * b[2];
                nr[2] = t[0] * b[1] - t[1] * b[0];
                ok = unit_vec(nr, n);
            end
            r = '0;
            if (ok)
            begin
                r.tangent_x = 16'(t[0]); r.tangent_y = 16'(t[1]); r.tangent_z = 16'(t[2]);
                r.binormal_x = 16'(b[0]); r.binormal_y = 16'(b[1]); r.binormal_z = 16'(b[2]);
                r.normal_x = 16'(n[0]); r.normal_y = 16'(n[1]); r.normal_z = 16'(n[2]);
            end
            r.degenerate = !ok;
            frames_due.push_back(r);
        endfunction

        function void check_frame(out_t a);
            out_t e;
            if (frames_due.size() == 0)
            begin
                $error("unexpected frame transaction %h", a);
                errors++;
                return;
            end
            e = frames_due.pop_front();
            if (a.tangent_x !== e.tangent_x) field_err("tangent_x", e.tangent_x, a.tangent_x);
            if (a.tangent_y !== e.tangent_y) field_err("tangent_y", e.tangent_y, a.tangent_y);
            if (a.tangent_z !== e.tangent_z) field_err("tangent_z", e.tangent_z, a.tangent_z);
            if (a.binormal_x !== e.binormal_x)
                field_err("binormal_x", e.binormal_x, a.binormal_x);
            if (a.binormal_y !== e.binormal_y)
                field_err("binormal_y", e.binormal_y, a.binormal_y);
            if (a.binormal_z !== e.binormal_z)
                field_err("binormal_z", e.binormal_z, a.binormal_z);
            if (a.normal_x !== e.normal_x) field_err("normal_x", e.normal_x, a.normal_x);
            if (a.normal_y !== e.normal_y) field_err("normal_y", e.normal_y, a.normal_y);
            if (a.normal_z !== e.normal_z) field_err("normal_z", e.normal_z, a.normal_z);
            if (a.degenerate !== e.degenerate)
                field_err("degenerate", e.degenerate, a.degenerate);
        endfunction

        function void field_err(string name, int e, int a);
            $error("%s: expected %0d, got %0d", name, e, a);
            errors++;
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_ready;
    in_t in_data = '0;
    logic out_valid;
    logic out_ready = 0;
    out_t out_data;

    int unsigned send_idle = 0;
    int unsigned recv_stall = 0;
    int unsigned hold_off = 0;
    longint unsigned cycles = 0;
    frame_board board = new();

    triangle_tangent_frame u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always #2 clk = ~clk;

    // Timeout guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 4000000)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: random stalls plus a long hold-off when requested
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) board.check_frame(out_data);
        if (hold_off != 0)
        begin
            hold_off <= hold_off - 1;
            out_ready <= 0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall);
    end

    function automatic logic [23:0] rnd_field();
        case ($urandom_range(5))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'($urandom_range(255)) - 24'd128;
            default: return 24'($urandom);
        endcase
    endfunction

    // Offer one vertex and wait for it to be accepted; valid stays up for the next call
    task automatic send_vertex(in_t d);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        in_data <= d;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_vertex(d);
    endtask

    task automatic send_vtx(int x, int y, int z, int u, int v);
        in_t d;
        d.pos_x = 24'(x); d.pos_y = 24'(y); d.pos_z = 24'(z);
        d.tex_u = 24'(u); d.tex_v = 24'(v);
        send_vertex(d);
    endtask

    task automatic send_random_triangle();
        in_t d[3];
        int mode;
        mode = $urandom_range(9);
        for (int k = 0; k < 3; k++)
        begin
            d[k].pos_x = rnd_field(); d[k].pos_y = rnd_field(); d[k].pos_z = rnd_field();
            d[k].tex_u = rnd_field(); d[k].tex_v = rnd_field();
        end
        // Occasionally force degenerate shapes
        if (mode == 0)
        begin
            d[2].tex_u = d[0].tex_u;
            d[2].tex_v = d[0].tex_v;
        end
        if (mode == 1) d[1] = d[0];
        if (mode == 2)
        begin
            d[2].pos_x = d[0].pos_x; d[2].pos_y = d[0].pos_y; d[2].pos_z = d[0].pos_z;
            d[1].pos_x = d[0].pos_x; d[1].pos_y = d[0].pos_y; d[1].pos_z = d[0].pos_z;
        end
        for (int k = 0; k < 3; k++) send_vertex(d[k]);
    endtask

    task automatic wait_drained();
        in_valid <= 0;
        while (board.frames_due.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: simple right triangle, extremes, degenerate cases
        send_vtx(0, 0, 0, 0, 0);
        send_vtx(65536, 0, 0, 65536, 0);
        send_vtx(0, 65536, 0, 0, 65536);
        send_vtx(-8388608, -8388608, -8388608, -8388608, -8388608);
        send_vtx(8388607, 8388607, 8388607, 8388607, -8388608);
        send_vtx(-8388608, 8388607, 0, -8388608, 8388607);
        // zero UV determinant
        send_vtx(1, 2, 3, 100, 100);
        send_vtx(5, 9, 1, 200, 200);
        send_vtx(7, 3, 8, 300, 300);
        // coincident positions
        send_vtx(500, 500, 500, 0, 0);
        send_vtx(500, 500, 500, 70000, 0);
        send_vtx(500, 500, 500, 0, 70000);
        // collinear positions: tangent parallel to binormal
        send_vtx(0, 0, 0, 0, 0);
        send_vtx(1000, 2000, 3000, 65536, 0);
        send_vtx(2000, 4000, 6000, 0, 65536);
        // negative determinant
        send_vtx(0, 0, 0, 0, 0);
        send_vtx(65536, 0, 0, 0, 65536);
        send_vtx(0, 65536, 0, 65536, 0);
        wait_drained();

        // Random phases with different idle patterns
        for (int p = 0; p < 4; p++)
        begin
            send_idle = (p == 1 || p == 3) ? ((p == 1) ? 77 : 11) : 0;
            recv_stall = (p == 2) ? 77 : ((p == 3) ? 11 : 0);
            if (p == 2) hold_off = 6000;
            for (int t = 0; t < 85; t++) send_random_triangle();
            wait_drained();
        end

        send_idle = 0;
        recv_stall = 0;
        repeat (2000) @(posedge clk);
        if (board.errors == 0 && board.frames_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

`default_nettype wire

// File: triangle_tangent_frame.f
+incdir+sv
sv/ttf_pkg.sv
sv/ttf_norm.sv
sv/triangle_tangent_frame.sv
verif/triangle_tangent_frame_test.sv
